// ===== hw/rtl/fpq_pkg.sv =====
// fpq_pkg: item types, codes and sizes shared by the four-level priority queue
// used by fpq_ctrl, fpq_dpath and four_level_priority_queue; no dependencies
package fpq_pkg;

	localparam int NameBytes = 20;
	localparam int NameBits  = 8 * NameBytes;
	localparam int Levels    = 4;

	// item kinds
	localparam logic KIND_ADMIT = 1'b0;
	localparam logic KIND_TAKE  = 1'b1;

	// result status codes
	localparam logic [2:0] ST_ADMITTED   = 3'd0;
	localparam logic [2:0] ST_EMPTY_NAME = 3'd1;
	localparam logic [2:0] ST_FULL       = 3'd2;
	localparam logic [2:0] ST_SERVED     = 3'd3;
	localparam logic [2:0] ST_NONE       = 3'd4;

	typedef struct packed {
		logic        kind;
		logic [1:0]  level;
		logic [63:0] admit_name_low;
		logic [63:0] admit_name_mid;
		logic [31:0] admit_name_high;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [1:0]  served_level;
		logic [63:0] served_name_low;
		logic [63:0] served_name_mid;
		logic [31:0] served_name_high;
		logic [4:0]  waiting;
	} out_item_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;  // capture the incoming item
		logic exec;  // decide, update pointers, access the name store
	} ctrl_cmd_t;

endpackage

// ===== hw/rtl/fpq_ctrl.sv =====
// fpq_ctrl: sequencing state machine of the priority queue
// depends on fpq_pkg for the command struct
module fpq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              done,
	output fpq_pkg::ctrl_cmd_t cmd
);
	import fpq_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t state_q, state_d;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				state_d = start ? S_EXEC : S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	// a new item may follow while the previous result is shown
	assign busy     = (state_q == S_EXEC);
	assign done     = (state_q == S_DONE);
	assign cmd.load = start && !busy;
	assign cmd.exec = (state_q == S_EXEC);

endmodule

// ===== hw/rtl/fpq_dpath.sv =====
// fpq_dpath: name store, per-level ring pointers, counts and result registers
// depends on fpq_pkg for item types, status codes and commands
module fpq_dpath #(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  fpq_pkg::ctrl_cmd_t cmd,
	input  fpq_pkg::in_item_t  item,
	output fpq_pkg::out_item_t result
);
	import fpq_pkg::*;

	localparam int PW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW    = $clog2(CAPACITY + 1);
	localparam int Depth = Levels << PW;
	localparam int AW    = PW + 2;

	// captured item
	in_item_t item_q;

	// ring state per level
	logic [PW-1:0] heads_q  [Levels];
	logic [PW-1:0] tails_q  [Levels];
	logic [CW-1:0] counts_q [Levels];
	logic [CW-1:0] total_q;

	// result registers
	logic [2:0]          status_q;
	logic [1:0]          slevel_q;
	logic [NameBits-1:0] rd_q;

	// name store
	logic [NameBits-1:0] mem [Depth];

	logic [NameBits-1:0] raw_name, clean_name;
	logic [NameBytes-1:0] zero_seen;
	logic                 name_empty, full, any_waiting;
	logic [1:0]           found;
	logic [2:0]           status_d;
	logic                 do_write, do_read;
	logic [PW-1:0]        wpos, rpos;
	logic [AW-1:0]        waddr, raddr;

	// transfer capture
	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= item;
	end

	// clear every byte after the first zero byte
	assign raw_name = {item_q.admit_name_high, item_q.admit_name_mid, item_q.admit_name_low};
	always_comb begin
		zero_seen[0] = 1'b0;
		for (int i = 1; i < NameBytes; i++) begin
			zero_seen[i] = zero_seen[i-1] | (raw_name[8*(i-1) +: 8] == 8'd0);
		end
		for (int i = 0; i < NameBytes; i++) begin
			clean_name[8*i +: 8] = zero_seen[i] ? 8'd0 : raw_name[8*i +: 8];
		end
	end

	// highest nonempty level
	always_comb begin
		found = 2'd0;
		for (int l = 0; l < Levels; l++) begin
			if (counts_q[l] != '0) found = 2'(l);
		end
	end

	assign name_empty  = (raw_name[7:0] == 8'd0);
	assign full        = (total_q == CW'(CAPACITY));
	assign any_waiting = (total_q != '0);

	// decision
	always_comb begin
		if (item_q.kind == KIND_ADMIT) begin
			if (name_empty) status_d = ST_EMPTY_NAME;
			else if (full)  status_d = ST_FULL;
			else            status_d = ST_ADMITTED;
		end else begin
			status_d = any_waiting ? ST_SERVED : ST_NONE;
		end
	end

	assign do_write = cmd.exec && (status_d == ST_ADMITTED);
	assign do_read  = cmd.exec && (status_d == ST_SERVED);
	assign wpos     = tails_q[item_q.level];
	assign rpos     = heads_q[found];
	assign waddr    = {item_q.level, wpos};
	assign raddr    = {found, rpos};

	// ring pointers and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < Levels; l++) begin
				heads_q[l]  <= '0;
				tails_q[l]  <= '0;
				counts_q[l] <= '0;
			end
			total_q <= '0;
		end else if (do_write) begin
			tails_q[item_q.level]  <= (wpos == PW'(CAPACITY - 1)) ? '0 : wpos + 1'b1;
			counts_q[item_q.level] <= counts_q[item_q.level] + 1'b1;
			total_q                <= total_q + 1'b1;
		end else if (do_read) begin
			heads_q[found]  <= (rpos == PW'(CAPACITY - 1)) ? '0 : rpos + 1'b1;
			counts_q[found] <= counts_q[found] - 1'b1;
			total_q         <= total_q - 1'b1;
		end
	end

	// name store write and registered read
	always_ff @(posedge clk) begin
		if (do_write) mem[waddr] <= clean_name;
		if (do_read)  rd_q <= mem[raddr];
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q <= status_d;
			slevel_q <= (status_d == ST_SERVED) ? found : 2'd0;
		end
	end

	// result fields, names zero unless served
	always_comb begin
		result.status       = status_q;
		result.served_level = slevel_q;
		if (status_q == ST_SERVED) begin
			result.served_name_low  = rd_q[63:0];
			result.served_name_mid  = rd_q[127:64];
			result.served_name_high = rd_q[159:128];
		end else begin
			result.served_name_low  = '0;
			result.served_name_mid  = '0;
			result.served_name_high = '0;
		end
		result.waiting = 5'(total_q);
	end

endmodule

// ===== hw/rtl/four_level_priority_queue.sv =====
// four_level_priority_queue: top level of the strict four-level priority queue
// depends on fpq_pkg, fpq_ctrl and fpq_dpath
//
// Usage:
//   An item is transferred at a rising edge where start is high and busy is low.
//   item.kind selects admit (store item's name at item.level) or take (remove
//   the oldest entry of the highest nonempty level).
//   Each item gives exactly one result, shown on result for one cycle while
//   done is high; the receiver cannot stall it and must take it then.
//   After the transfer the controller passes through S_EXEC, where the decision is
//   made, and then raises done in S_DONE; busy is high in S_EXEC, so no item is
//   taken then, and the name store gives at most one registered read or one write per item.
//   A new item may be transferred while the previous result is shown.
//   Reset clears the ring pointers and counts, so the queue starts empty; the
//   name store itself is not cleared and needs no clearing pass.
//   result.waiting holds the low five bits of the entries left waiting.
module four_level_priority_queue #(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  fpq_pkg::in_item_t  item,
	output logic               done,
	output fpq_pkg::out_item_t result
);
	import fpq_pkg::*;

	ctrl_cmd_t cmd;

	// sequencing
	fpq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// storage and decision
	fpq_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.result (result)
	);

endmodule

// ===== verif/four_level_priority_queue_tb.sv =====
// four_level_priority_queue_tb: self-checking bench for the four-level priority queue
// needs fpq_pkg and four_level_priority_queue; directed then bursty random admit/take
// traffic, every result checked against a shadow queue kept in the bench
module four_level_priority_queue_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import fpq_pkg::*;

	localparam int QCAP     = 16;
	localparam int N_RANDOM = 900;

	typedef struct {
		in_item_t cmd;
		bit       drain;  // hold this one back until no reply is outstanding
	} job_t;

	logic      clk    = 1'b0;
	logic      arst_n = 1'b0;
	logic      start  = 1'b0;
	in_item_t  item   = '0;
	logic      busy;
	logic      done;
	out_item_t result;

	job_t      job_q[$];
	out_item_t reply_q[$];
	int        fail_cnt = 0;
	int        sent_cnt = 0;
	int        plan_cnt = 0;
	bit        took     = 1'b0;

	// shadow of the queue: one ring of names per level
	logic [NameBits-1:0] ring [Levels][QCAP];
	int head    [Levels];
	int tail    [Levels];
	int lvl_cnt [Levels];
	int total = 0;

	four_level_priority_queue #(.CAPACITY(QCAP)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	always #10ns clk = ~clk;

	// apply one admit or take to the shadow queue and return its reply
	function automatic out_item_t pq_apply(in_item_t c);
		out_item_t           r;
		logic [NameBits-1:0] nm;
		bit                  ended;
		int                  lv;
		r = '0;
		if (c.kind == KIND_ADMIT) begin
			nm = {c.admit_name_high, c.admit_name_mid, c.admit_name_low};
			// everything after the first zero byte is dropped
			ended = 1'b0;
			for (int b = 0; b < NameBytes; b++) begin
				if (ended) nm[8*b +: 8] = 8'h00;
				else if (nm[8*b +: 8] == 8'h00) ended = 1'b1;
			end
			if (nm[7:0] == 8'h00) begin
				r.status = ST_EMPTY_NAME;
			end else if (total >= QCAP) begin
				r.status = ST_FULL;
			end else begin
				ring[c.level][tail[c.level]] = nm;
				tail[c.level] = (tail[c.level] + 1) % QCAP;
				lvl_cnt[c.level]++;
				total++;
				r.status = ST_ADMITTED;
			end
		end else begin
			// highest nonempty level wins, oldest entry within it
			lv = -1;
			for (int l = Levels - 1; l >= 0; l--)
				if (lv < 0 && lvl_cnt[l] != 0) lv = l;
			if (lv < 0) begin
				r.status = ST_NONE;
			end else begin
				nm = ring[lv][head[lv]];
				head[lv] = (head[lv] + 1) % QCAP;
				lvl_cnt[lv]--;
				total--;
				r.status           = ST_SERVED;
				r.served_level     = lv[1:0];
				r.served_name_low  = nm[63:0];
				r.served_name_mid  = nm[127:64];
				r.served_name_high = nm[159:128];
			end
		end
		r.waiting = total[4:0];
		return r;
	endfunction

	function automatic void push_cmd(logic k, logic [1:0] lv, logic [NameBits-1:0] nm, bit drain);
		job_t j;
		j.cmd.kind            = k;
		j.cmd.level           = lv;
		j.cmd.admit_name_low  = nm[63:0];
		j.cmd.admit_name_mid  = nm[127:64];
		j.cmd.admit_name_high = nm[159:128];
		j.drain               = drain;
		job_q.push_back(j);
	endfunction

	// random name: mostly valid, some empty, some cut short by an inner zero byte
	function automatic logic [NameBits-1:0] rand_name();
		logic [NameBits-1:0] nm;
		int                  pick;
		nm   = {$urandom, $urandom, $urandom, $urandom, $urandom};
		pick = $urandom_range(99);
		if (pick < 6) begin
			nm[7:0] = 8'h00;
		end else begin
			nm[0] = 1'b1;
			if (pick < 22) nm[8*$urandom_range(NameBytes - 1, 1) +: 8] = 8'h00;
		end
		return nm;
	endfunction

	// stimulus, reset and end of run
	initial begin : stim
		logic [NameBits-1:0] nm;
		int                  burst;
		int                  admit_pct;
		int                  n;

		// directed: empty take, empty names, fill to capacity, full, drain a few
		push_cmd(KIND_TAKE, 2'd3, '1, 1'b0);
		push_cmd(KIND_ADMIT, 2'd0, '0, 1'b0);
		nm = '1;
		nm[7:0] = 8'h00;
		push_cmd(KIND_ADMIT, 2'd3, nm, 1'b0);
		push_cmd(KIND_ADMIT, 2'd3, '1, 1'b0);
		nm = {NameBytes{8'ha5}};
		nm[47:40] = 8'h00;
		push_cmd(KIND_ADMIT, 2'd0, nm, 1'b0);
		nm = {NameBytes{8'h3c}};
		nm[15:8] = 8'h00;
		push_cmd(KIND_ADMIT, 2'd2, nm, 1'b0);
		for (int i = 0; i < 13; i++) begin
			nm = {$urandom, $urandom, $urandom, $urandom, $urandom};
			nm[0] = 1'b1;
			push_cmd(KIND_ADMIT, 2'(i % Levels), nm, 1'b0);
		end
		push_cmd(KIND_ADMIT, 2'd1, '1, 1'b0);
		push_cmd(KIND_ADMIT, 2'd1, '0, 1'b0);
		for (int i = 0; i < 4; i++)
			push_cmd(KIND_TAKE, 2'(i), '0, 1'b0);

		// random: admit-heavy and take-heavy bursts so the queue fills and empties
		n = 0;
		while (n < N_RANDOM) begin
			burst     = $urandom_range(22, 3);
			admit_pct = $urandom_range(1) ? 88 : 12;
			for (int i = 0; i < burst; i++) begin
				if ($urandom_range(99) < 8)
					push_cmd(1'($urandom_range(1)), 2'($urandom_range(3)),
						{$urandom, $urandom, $urandom, $urandom, $urandom}, n == 0);
				else
					push_cmd(($urandom_range(99) < admit_pct) ? KIND_ADMIT : KIND_TAKE,
						2'($urandom_range(3)), rand_name(),
						n == 0 || $urandom_range(199) == 0);
				n++;
			end
		end
		plan_cnt = job_q.size();
		job_q[plan_cnt / 3].drain     = 1'b1;
		job_q[2 * plan_cnt / 3].drain = 1'b1;

		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		while (job_q.size() != 0 || start) @(negedge clk);
		while (reply_q.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (fail_cnt == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin : watchdog
		#5ms;
		$display("FAIL");
		$finish;
	end

	// driver: new item or idle at the falling edge once the last one transferred
	always @(negedge clk) begin : drive
		int gap_pct;
		if (arst_n && (!start || took)) begin
			took = 1'b0;
			if (sent_cnt < plan_cnt / 3) gap_pct = 35;
			else if (sent_cnt < 2 * plan_cnt / 3) gap_pct = 56;
			else gap_pct = 0;
			if (job_q.size() == 0 || (job_q[0].drain && reply_q.size() != 0)
					|| $urandom_range(99) < gap_pct) begin
				start <= 1'b0;
			end else begin
				item  <= job_q[0].cmd;
				start <= 1'b1;
				void'(job_q.pop_front());
				sent_cnt++;
			end
		end
	end

	// monitor: check each result, then log the transfer at this edge
	always @(posedge clk) begin : watch
		out_item_t want;
		if (arst_n) begin
			if (done) begin
				if (reply_q.size() == 0) begin
					$error("result with no transfer pending: status %0d", result.status);
					fail_cnt++;
				end else begin
					want = reply_q.pop_front();
					if (result.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, result.status);
						fail_cnt++;
					end
					if (result.served_level !== want.served_level) begin
						$error("served_level: expected %0d, got %0d",
							want.served_level, result.served_level);
						fail_cnt++;
					end
					if (result.served_name_low !== want.served_name_low) begin
						$error("served_name_low: expected %h, got %h",
							want.served_name_low, result.served_name_low);
						fail_cnt++;
					end
					if (result.served_name_mid !== want.served_name_mid) begin
						$error("served_name_mid: expected %h, got %h",
							want.served_name_mid, result.served_name_mid);
						fail_cnt++;
					end
					if (result.served_name_high !== want.served_name_high) begin
						$error("served_name_high: expected %h, got %h",
							want.served_name_high, result.served_name_high);
						fail_cnt++;
					end
					if (result.waiting !== want.waiting) begin
						$error("waiting: expected %0d, got %0d", want.waiting, result.waiting);
						fail_cnt++;
					end
				end
			end
			if (start && !busy) begin
				reply_q.push_back(pq_apply(item));
				took = 1'b1;
			end
		end
	end

endmodule
